// ===== rtl/core/fsg_pkg.sv =====
// Shared types and constants for the falling sand grid block.
package fsg_pkg;

    localparam int OP_W    = 2;
    localparam int COORD_W = 8;
    localparam int COLOR_W = 16;
    localparam int SEED_W  = 16;

    localparam logic [SEED_W-1:0] SEED_DEFAULT = 16'hACE1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2
    } op_t;

endpackage

// ===== rtl/core/fsg_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module fsg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/falling_sand_grid_step.sv =====
// Falling sand grid: cell store, read/write access and the in-place world step.
// Input stream (s_axis_*): one item per command; tuser carries the operation
//   (write cell, read cell, world step), tdata carries x_pos, y_pos, cell_color.
// Output stream (m_axis_*): exactly one item per command, in order; tuser echoes
//   the operation, tdata holds the cell color for a read, else 0.
// cfg_we/cfg_wdata load the tie-break LFSR seed (0 loads the default seed);
//   write it only while the block is idle.
// Timing: a write, an unknown code or an off-grid read goes from S_IDLE through
//   S_DONE into the output register, an on-grid read through S_RDWAIT and S_DONE;
//   the next item is taken only once the block is back in S_IDLE.
// World step: the scan visits every row above the bottom one; an empty cell passes
//   S_FETCH and S_CHK, a straight drop adds S_BELOW and S_CLRSRC, and a cell that
//   probes both diagonals also passes S_LEFT and S_RIGHT, the grid RAM taking a
//   single access per cycle. s_axis_tready is high only when idle.
// Reset: after rst_n rises the block sweeps the grid to empty, one cell a cycle,
//   with s_axis_tready low. The LFSR is loaded with the default seed at reset.
// Stall: a finished result sits in the output register until taken; the next
//   item is accepted meanwhile, and its own result waits until the register frees.
module falling_sand_grid_step #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input item
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // x_pos[7:0], y_pos[15:8], cell_color[31:16]
    input  logic [fsg_pkg::OP_W-1:0]      s_axis_tuser,  // operation[1:0]
    // result item
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [fsg_pkg::COLOR_W-1:0]   m_axis_tdata,  // read_color[15:0]
    output logic [fsg_pkg::OP_W-1:0]      m_axis_tuser,  // done_operation[1:0]
    // seed register
    input  logic                          cfg_we,
    input  logic [fsg_pkg::SEED_W-1:0]    cfg_wdata
);

    import fsg_pkg::*;

    localparam int DEPTH   = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int XW      = $clog2(GRID_WIDTH);
    localparam int YW      = $clog2(GRID_HEIGHT);
    // bottom row never moves, so the scan starts one row up
    localparam int START_Y = GRID_HEIGHT - 2;
    localparam int START_X = (START_Y % 2 == 1) ? 0 : GRID_WIDTH - 1;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_RDWAIT = 10'b00_0000_0100,
        S_FETCH  = 10'b00_0000_1000,
        S_CHK    = 10'b00_0001_0000,
        S_BELOW  = 10'b00_0010_0000,
        S_LEFT   = 10'b00_0100_0000,
        S_RIGHT  = 10'b00_1000_0000,
        S_CLRSRC = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [XW-1:0]        x_reg, x_next;
    logic [YW-1:0]        y_reg, y_next;
    logic [COLOR_W-1:0]   cur_reg, cur_next;
    logic                 left_ok_reg, left_ok_next;
    logic [SEED_W-1:0]    lfsr_reg, lfsr_next;
    logic [COLOR_W-1:0]   res_color_reg, res_color_next;
    logic [OP_W-1:0]      res_op_reg, res_op_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]   out_color_reg, out_color_next;
    logic [OP_W-1:0]      out_op_reg, out_op_next;

    // grid RAM port signals
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [COLOR_W-1:0]   mem_wdata;
    logic [COLOR_W-1:0]   mem_rdata;
    logic                 use_clr;
    logic [XW-1:0]        ax;
    logic [YW-1:0]        ay;

    logic                 in_acc;
    logic                 in_inside;
    logic [XW-1:0]        in_x;
    logic [YW-1:0]        in_y;
    logic                 adv;
    logic                 row_end;
    logic                 lfsr_fb;
    logic                 right_ok;
    logic                 go_left;
    logic                 move;
    logic                 out_free;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign in_inside = (int'(s_axis_tdata[7:0]) < GRID_WIDTH)
                    && (int'(s_axis_tdata[15:8]) < GRID_HEIGHT);
    assign in_x      = XW'(s_axis_tdata[7:0]);
    assign in_y      = YW'(s_axis_tdata[15:8]);

    assign lfsr_fb   = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    // odd rows run left to right, even rows right to left
    assign row_end   = y_reg[0] ? (x_reg == XW'(GRID_WIDTH - 1)) : (x_reg == '0);
    assign out_free  = !out_valid_reg || m_axis_tready;

    // one shared address generator: row * width + column
    assign mem_addr  = use_clr ? clr_reg : AW'(int'(ay) * GRID_WIDTH + int'(ax));

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cur_next       = cur_reg;
        left_ok_next   = left_ok_reg;
        lfsr_next      = lfsr_reg;
        res_color_next = res_color_reg;
        res_op_next    = res_op_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_color_next = out_color_reg;
        out_op_next    = out_op_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        use_clr        = 1'b0;
        ax             = x_reg;
        ay             = y_reg;
        adv            = 1'b0;
        right_ok       = 1'b0;
        go_left        = 1'b0;
        move           = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                use_clr  = 1'b1;
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ax = in_x;
                ay = in_y;
                if (in_acc)
                begin
                    res_op_next    = s_axis_tuser;
                    res_color_next = '0;
                    priority if (s_axis_tuser == OP_WRITE)
                    begin
                        mem_we     = in_inside;
                        mem_wdata  = s_axis_tdata[31:16];
                        state_next = S_DONE;
                    end
                    else if (s_axis_tuser == OP_READ)
                    begin
                        state_next = in_inside ? S_RDWAIT : S_DONE;
                    end
                    else if (s_axis_tuser == OP_STEP)
                    begin
                        x_next     = XW'(START_X);
                        y_next     = YW'(START_Y);
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RDWAIT:
            begin
                res_color_next = mem_rdata;
                state_next     = S_DONE;
            end
            S_FETCH:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cur_next = mem_rdata;
                if (mem_rdata == '0)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    ay         = y_reg + 1'b1;
                    state_next = S_BELOW;
                end
            end
            S_BELOW:
            begin
                ay = y_reg + 1'b1;
                if (mem_rdata == '0)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = cur_reg;
                    state_next = S_CLRSRC;
                end
                else if (x_reg != '0)
                begin
                    ax         = x_reg - 1'b1;
                    state_next = S_LEFT;
                end
                else if (x_reg != XW'(GRID_WIDTH - 1))
                begin
                    ax           = x_reg + 1'b1;
                    left_ok_next = 1'b0;
                    state_next   = S_RIGHT;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_LEFT:
            begin
                ay           = y_reg + 1'b1;
                left_ok_next = (mem_rdata == '0);
                if (x_reg != XW'(GRID_WIDTH - 1))
                begin
                    ax         = x_reg + 1'b1;
                    state_next = S_RIGHT;
                end
                else if (mem_rdata == '0)
                begin
                    ax         = x_reg - 1'b1;
                    mem_we     = 1'b1;
                    mem_wdata  = cur_reg;
                    state_next = S_CLRSRC;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_RIGHT:
            begin
                ay       = y_reg + 1'b1;
                right_ok = (mem_rdata == '0);
                // both diagonals free: LFSR feedback bit picks, 1 = left
                priority if (left_ok_reg && right_ok)
                begin
                    lfsr_next = {lfsr_fb, lfsr_reg[SEED_W-1:1]};
                    go_left   = lfsr_fb;
                    move      = 1'b1;
                end
                else if (left_ok_reg)
                begin
                    go_left = 1'b1;
                    move    = 1'b1;
                end
                else if (right_ok)
                begin
                    move = 1'b1;
                end
                else
                begin
                    adv = 1'b1;
                end
                if (move)
                begin
                    ax         = go_left ? x_reg - 1'b1 : x_reg + 1'b1;
                    mem_we     = 1'b1;
                    mem_wdata  = cur_reg;
                    state_next = S_CLRSRC;
                end
            end
            S_CLRSRC:
            begin
                mem_we = 1'b1;
                adv    = 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_color_next = res_color_reg;
                    out_op_next    = res_op_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // move to the next cell of the serpentine scan
        if (adv)
        begin
            if (row_end)
            begin
                if (y_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    y_next     = y_reg - 1'b1;
                    x_next     = y_reg[0] ? XW'(GRID_WIDTH - 1) : '0;
                    state_next = S_FETCH;
                end
            end
            else
            begin
                x_next     = y_reg[0] ? x_reg + 1'b1 : x_reg - 1'b1;
                state_next = S_FETCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            lfsr_reg      <= SEED_DEFAULT;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                lfsr_reg <= (cfg_wdata != '0) ? cfg_wdata : SEED_DEFAULT;
            end
            else
            begin
                lfsr_reg <= lfsr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        cur_reg       <= cur_next;
        left_ok_reg   <= left_ok_next;
        res_color_reg <= res_color_next;
        res_op_reg    <= res_op_next;
        out_color_reg <= out_color_next;
        out_op_reg    <= out_op_next;
    end

    fsg_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_color_reg;
    assign m_axis_tuser  = out_op_reg;

endmodule

// ===== rtl/core/fsg_checker.sv =====
// Port-level checker for the falling sand grid block, bound to the top level.
module fsg_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [fsg_pkg::COLOR_W-1:0]   m_axis_tdata,
    input  logic [fsg_pkg::OP_W-1:0]      m_axis_tuser
);

    import fsg_pkg::*;

    // only a read returns a color
    a_color_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != OP_READ) |-> m_axis_tdata == '0)
        else $error("nonzero color on a non-read result");

    // one command in flight: input closes right after an item is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // grid clear sweep runs first after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("block open before the clear sweep");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind falling_sand_grid_step fsg_checker u_fsg_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the falling sand grid: cell access, world steps, seed register.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import fsg_pkg::*;

    localparam int GRID_W      = 256;
    localparam int GRID_H      = 192;
    localparam int GRID_CELLS  = GRID_W * GRID_H;
    localparam int HOLD_CYCLES = 200;      // long receiver hold-off for the backpressure test
    // The watchdog limit lies well above the longest stretch without a handshake: a full
    // world step on the grid, or the reset sweep.
    localparam int STALL_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = 16;

    // code the block does not define; it must still echo it with a zero color
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COLOR_W-1:0] color;
    } result_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata  = '0;    // x_pos[7:0], y_pos[15:8], cell_color[31:16]
    logic [OP_W-1:0]     s_axis_tuser  = '0;    // operation[1:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [COLOR_W-1:0]  m_axis_tdata;          // read_color[15:0]
    logic [OP_W-1:0]     m_axis_tuser;          // done_operation[1:0]
    logic                cfg_we        = 1'b0;
    logic [SEED_W-1:0]   cfg_wdata     = '0;

    always #5 clk = ~clk;

    falling_sand_grid_step #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the grid and the tie-break LFSR
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] sand_grid [GRID_CELLS];
    logic [SEED_W-1:0]  tie_state;

    result_t pending_results [$];   // expected results, oldest first

    int errors          = 0;
    int items_sent      = 0;
    int steps_sent      = 0;
    int occupied_reads  = 0;
    int send_idle_pct   = 0;        // chance per cycle that the sender holds back
    int recv_stall_pct  = 0;        // chance per cycle that the receiver drops tready
    int hold_requests   = 0;        // bumped by a test to ask for one long hold-off
    int holds_served    = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    // One bit of the tie LFSR: taps 0,2,3,5, shifting right, feedback into bit 15.
    function automatic logic draw_tie_bit();
        logic fb;
        fb = tie_state[0] ^ tie_state[2] ^ tie_state[3] ^ tie_state[5];
        tie_state = {fb, tie_state[SEED_W-1:1]};
        return fb;
    endfunction

    function automatic void settle_grain(int x, int y);
        logic [COLOR_W-1:0] grain;
        bit                 left_ok;
        bit                 right_ok;
        grain = sand_grid[y*GRID_W + x];
        if (grain == '0 || y + 1 >= GRID_H)
            return;
        // straight down wins whenever the cell below is empty
        if (sand_grid[(y+1)*GRID_W + x] == '0) begin
            sand_grid[(y+1)*GRID_W + x] = grain;
            sand_grid[y*GRID_W + x] = '0;
            return;
        end
        left_ok  = (x > 0) && (sand_grid[(y+1)*GRID_W + x - 1] == '0);
        right_ok = (x + 1 < GRID_W) && (sand_grid[(y+1)*GRID_W + x + 1] == '0);
        // both diagonals open: the LFSR bit decides, 1 goes left
        if (left_ok && right_ok) begin
            if (draw_tie_bit())
                right_ok = 1'b0;
            else
                left_ok = 1'b0;
        end
        if (left_ok) begin
            sand_grid[(y+1)*GRID_W + x - 1] = grain;
            sand_grid[y*GRID_W + x] = '0;
        end
        else if (right_ok) begin
            sand_grid[(y+1)*GRID_W + x + 1] = grain;
            sand_grid[y*GRID_W + x] = '0;
        end
    endfunction

    // Bottom row first; odd rows left to right, even rows right to left.
    function automatic void world_step_model();
        int y;
        for (int r = 0; r < GRID_H; r++) begin
            y = GRID_H - 1 - r;
            for (int i = 0; i < GRID_W; i++)
                settle_grain((y % 2 == 1) ? i : GRID_W - 1 - i, y);
        end
    endfunction

    // Applies one accepted command to the shadow grid and returns its result.
    function automatic result_t apply_command(logic [OP_W-1:0] op, logic [COORD_W-1:0] x,
                                              logic [COORD_W-1:0] y, logic [COLOR_W-1:0] color);
        result_t res;
        bit      on_grid;
        on_grid   = (int'(x) < GRID_W) && (int'(y) < GRID_H);
        res.op    = op;
        res.color = '0;
        case (op)
            OP_WRITE: if (on_grid) sand_grid[int'(y)*GRID_W + int'(x)] = color;
            OP_READ:  if (on_grid) res.color = sand_grid[int'(y)*GRID_W + int'(x)];
            OP_STEP:  world_step_model();
            default:  ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared sender: optional idle gap, then hold the item until taken.
    // tvalid is left high on return so back-to-back items need no toggle.
    // ------------------------------------------------------------------
    task automatic send_command(logic [OP_W-1:0] op, logic [COORD_W-1:0] x,
                                logic [COORD_W-1:0] y, logic [COLOR_W-1:0] color);
        result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {color, y, x};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = apply_command(op, x, y, color);
        pending_results.push_back(res);
        items_sent++;
        if (op == OP_STEP)
            steps_sent++;
        if (op == OP_READ && res.color != '0)
            occupied_reads++;
    endtask

    // Sender goes quiet until every expected result has been taken.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Seed load: only with the block idle. Zero loads the default seed.
    task automatic load_seed(logic [SEED_W-1:0] seed);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tie_state = (seed == '0) ? SEED_DEFAULT : seed;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a counted hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: every taken result against the oldest expectation.
    always @(posedge clk) begin : check_results
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, got color %h op %0d",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.color) begin
                    $display("%0t ns: read_color mismatch, expected %h got %h",
                             $time, want.color, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== want.op) begin
                    $display("%0t ns: done_operation mismatch, expected %0d got %0d",
                             $time, want.op, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Writes and reads at two opposite grid corners, off-grid rows, clearing a cell, unused code.
    task automatic test_cell_access();
        send_command(OP_WRITE, 8'd0,   8'd0,   16'hFFFF);
        send_command(OP_WRITE, 8'd255, 8'd191, 16'h0001);
        send_command(OP_WRITE, 8'd128, 8'd192, 16'h1234);   // first row past the grid
        send_command(OP_READ,  8'd0,   8'd0,   16'h0000);
        send_command(OP_READ,  8'd255, 8'd191, 16'h0000);
        send_command(OP_READ,  8'd128, 8'd192, 16'h0000);
        send_command(OP_READ,  8'd7,   8'd255, 16'hFFFF);
        send_command(OP_WRITE, 8'd0,   8'd0,   16'h0000);   // zero color empties the cell
        send_command(OP_READ,  8'd0,   8'd0,   16'h0000);
        send_command(OP_UNUSED, 8'hAA, 8'h55,  16'hA5A5);
    endtask

    // One step over a layout holding every movement case, on the reset seed.
    task automatic test_sand_moves();
        send_command(OP_WRITE, 8'd100, 8'd50,  16'hC001);   // free fall
        send_command(OP_WRITE, 8'd50,  8'd191, 16'hC002);   // floor grain
        send_command(OP_WRITE, 8'd50,  8'd190, 16'hC003);   // both diagonals open: tie
        send_command(OP_WRITE, 8'd0,   8'd191, 16'hC004);
        send_command(OP_WRITE, 8'd0,   8'd190, 16'hC005);   // left edge: only right open
        send_command(OP_WRITE, 8'd255, 8'd190, 16'hC006);   // right edge: only left open
        send_command(OP_WRITE, 8'd200, 8'd191, 16'hC007);
        send_command(OP_WRITE, 8'd199, 8'd191, 16'hC008);
        send_command(OP_WRITE, 8'd201, 8'd191, 16'hC009);
        send_command(OP_WRITE, 8'd200, 8'd190, 16'hC00A);   // boxed in: stays
        send_command(OP_STEP,  8'd0,   8'd0,   16'h0000);
        send_command(OP_READ,  8'd100, 8'd51,  16'h0000);
        send_command(OP_READ,  8'd49,  8'd191, 16'h0000);
        send_command(OP_READ,  8'd51,  8'd191, 16'h0000);
        send_command(OP_READ,  8'd1,   8'd191, 16'h0000);
        send_command(OP_READ,  8'd254, 8'd191, 16'h0000);
        send_command(OP_READ,  8'd200, 8'd190, 16'h0000);
    endtask

    // Receiver holds off while items keep coming, so the block fills and blocks input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_results_drained();
        hold_requests++;
        for (int i = 0; i < 8; i++) begin
            if (i % 2 == 0)
                send_command(OP_WRITE, 8'(30 + i), 8'd100, 16'($urandom_range(1, 65535)));
            else
                send_command(OP_READ, 8'(29 + i), 8'd100, 16'h0000);
        end
        wait_results_drained();
    endtask

    // Random mix around a small pile near the floor, one step per phase, given seed, idling and stalling.
    task automatic test_seed_phase(int n_items, logic [SEED_W-1:0] seed, int idle_pct,
                                   int stall_pct);
        int                 roll;
        int                 step_slot;
        int                 base_x;
        int                 base_y;
        logic [COLOR_W-1:0] color;
        load_seed(seed);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        base_x    = $urandom_range(1, 246);
        base_y    = $urandom_range(184, 187);
        step_slot = $urandom_range(n_items / 3, n_items - 4);
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (i == step_slot)
                send_command(OP_STEP, 8'($urandom), 8'($urandom), 16'($urandom));
            else if (roll < 45) begin
                color = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
                send_command(OP_WRITE, 8'(base_x + $urandom_range(0, 5)),
                             8'($urandom_range(base_y, GRID_H - 1)), color);
            end
            else if (roll < 55)
                send_command(OP_WRITE, 8'($urandom), 8'($urandom), 16'($urandom));
            else if (roll < 88)
                send_command(OP_READ, 8'(base_x - 1 + $urandom_range(0, 7)),
                             8'($urandom_range(base_y, GRID_H - 1)), 16'($urandom));
            else if (roll < 95)
                send_command(OP_READ, 8'($urandom), 8'($urandom), 16'($urandom));
            else
                send_command(OP_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
        end
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < GRID_CELLS; i++)
            sand_grid[i] = '0;
        tie_state = SEED_DEFAULT;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cell_access();
        test_sand_moves();
        test_backpressure();
        test_seed_phase(20, 16'h0001, 0, 0);
        test_seed_phase(20, 16'hFFFF, 64, 0);
        test_seed_phase(20, 16'h0000, 0, 64);
        test_seed_phase(20, 16'($urandom_range(2, 65534)), 19, 19);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived",
                     $time, pending_results.size());
            errors++;
        end

        $display("Ran %0d commands including %0d world steps; %0d reads hit occupied cells.",
                 items_sent, steps_sent, occupied_reads);
        $display("Seeds covered: reset default, 1, 0xFFFF, zero, one random; %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/fsg_pkg.sv
rtl/core/fsg_ram.sv
rtl/core/falling_sand_grid_step.sv
rtl/core/fsg_checker.sv
tb/testbench.sv
